/* rtl/core/corner_min_distance_filter_top_defines.svh */
// Assertion macros for the corner minimum-distance filter.
// Included by corner_min_distance_filter_top.sv, which carries concurrent assertions; no dependencies.
`ifndef CORNER_MIN_DISTANCE_FILTER_TOP_DEFINES_SVH
`define CORNER_MIN_DISTANCE_FILTER_TOP_DEFINES_SVH
`ifndef SYNTH
`define CMDF_ASSERT(lbl, clk_s, rstn_s, prop_e, msg_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop_e)) else $error(msg_s);
`define CMDF_ASSERT_NXT(lbl, clk_s, rstn_s, ante_e, cons_e, msg_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante_e) |=> (cons_e)) \
	else $error(msg_s);
`else
`define CMDF_ASSERT(lbl, clk_s, rstn_s, prop_e, msg_s)
`define CMDF_ASSERT_NXT(lbl, clk_s, rstn_s, ante_e, cons_e, msg_s)
`endif
`endif

/* rtl/core/cmdf_pkg.sv */
// Package for the corner minimum-distance filter: register widths, reset values,
// register indexes and parameter defaults. No dependencies.
`default_nettype none
package cmdf_pkg;
	localparam int CS_W = 11;
	localparam int MD_W = 24;
	localparam int MC_W = 9;
	localparam int MAX_KEPT_DEF = 256;
	localparam int COORD_BITS_DEF = 11;
	localparam logic [CS_W-1:0] CELL_SIZE_RST = CS_W'(10);
	localparam logic [MD_W-1:0] MIN_DIST_SQ_RST = MD_W'(100);
	localparam logic [MC_W-1:0] MAX_CORNERS_RST = '0;
	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_MIN_DIST_SQ = 2'd1;
	localparam logic [1:0] REG_MAX_CORNERS = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/corner_min_distance_filter_top.sv */
// Corner minimum-distance filter: grid-cell division, scan of the kept-corner
// memory and acceptance bookkeeping. Depends on cmdf_pkg and the defines header.
//
// Channel   Direction  Handshake                         Payload
// config    in/out     psel, penable, pwrite, pready     paddr, pwdata, prdata
// command   in         start accepted when busy is low    col, row, first
// result    out        res_valid, one cycle               accepted, out_col, out_row, done_res
//
// A transaction runs from start to res_valid through the division and the scan: the
// restoring divider resolves one cell bit a cycle, then the kept-corner memory, when any
// corners are kept in the frame, is read one entry a cycle through a three-stage compare
// against the neighbor-cell pixel bounds.
// A candidate arriving after the budget is used up skips both.
// busy is high from the accepting edge until res_valid; reset clears the state, count, flags and outputs.
// The receiver cannot stall; results are strobed for one cycle.
`default_nettype none
`include "corner_min_distance_filter_top_defines.svh"
module corner_min_distance_filter_top
	import cmdf_pkg::*;
#(
	parameter int MAX_KEPT = MAX_KEPT_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COORD_BITS-1:0] col,
	input  wire logic [COORD_BITS-1:0] row,
	input  wire logic                  first,
	output logic                       res_valid,
	output logic                       accepted,
	output logic      [COORD_BITS-1:0] out_col,
	output logic      [COORD_BITS-1:0] out_row,
	output logic                       done_res
);
	localparam int CNT_W = $clog2(MAX_KEPT + 1);
	localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int DC_W = $clog2(COORD_BITS + 1);
	localparam int ENT_W = 2 * COORD_BITS;
	localparam int SQ_W = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > MD_W) ? SUM_W : MD_W;
	localparam int LIM_W = (MC_W > CNT_W) ? MC_W : CNT_W;
	localparam int BND_W = COORD_BITS + CS_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_FIN} state_t;

	logic [CS_W-1:0] cell_size_q;
	logic [MD_W-1:0] min_dist_sq_q;
	logic [MC_W-1:0] max_corners_q;
	logic            cfg_wr;

	state_t          state_q;
	logic [DC_W-1:0] div_cnt_q;
	logic [CNT_W-1:0] scan_addr_q;
	logic [CNT_W-1:0] kept_count_q;
	logic            budget_q;
	logic            blk_q;
	logic            hit_q;
	logic            v_s1, v_s2, v_s3;
	logic            res_valid_q, accepted_q, done_res_q;
	logic [COORD_BITS-1:0] out_col_q, out_row_q;

	logic [COORD_BITS-1:0] c_q, r_q;
	logic [COORD_BITS-1:0] dvc_q, dvr_q;
	logic [CS_W-1:0]       remc_q, remr_q;
	logic [BND_W-1:0]      lo_c_q, hi_c_q, lo_r_q, hi_r_q;
	logic [ENT_W-1:0]      kept_mem [MAX_KEPT];
	logic [ENT_W-1:0]      rd_data_s1;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic                  near_s2, near_s3;
	logic [SQ_W-1:0]       sqx_s3, sqy_s3;

	logic [CS_W-1:0]       cs_eff;
	logic [CS_W:0]         shc, shr;
	logic                  gec, ger;
	logic [CS_W-1:0]       remc_n, remr_n;
	logic                  rd_en;
	logic                  drained;
	logic [COORD_BITS-1:0] k_col, k_row;
	logic [COORD_BITS-1:0] dx_n, dy_n;
	logic [SUM_W-1:0]      dist_sum;
	logic                  lt;
	logic                  acc;
	logic [CNT_W-1:0]      cnt_inc;
	logic [LIM_W-1:0]      mc_ext, lim;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_SIZE_RST;
			min_dist_sq_q <= MIN_DIST_SQ_RST;
			max_corners_q <= MAX_CORNERS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CELL_SIZE: cell_size_q <= pwdata[CS_W-1:0];
				REG_MIN_DIST_SQ: min_dist_sq_q <= pwdata[MD_W-1:0];
				REG_MAX_CORNERS: max_corners_q <= pwdata[MC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CELL_SIZE: prdata = 32'(cell_size_q);
			REG_MIN_DIST_SQ: prdata = 32'(min_dist_sq_q);
			REG_MAX_CORNERS: prdata = 32'(max_corners_q);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cs_eff = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
		shc = {remc_q, dvc_q[COORD_BITS-1]};
		shr = {remr_q, dvr_q[COORD_BITS-1]};
		gec = shc >= {1'b0, cs_eff};
		ger = shr >= {1'b0, cs_eff};
		remc_n = gec ? CS_W'(shc - {1'b0, cs_eff}) : shc[CS_W-1:0];
		remr_n = ger ? CS_W'(shr - {1'b0, cs_eff}) : shr[CS_W-1:0];
	end

	assign rd_en = (state_q == ST_SCAN) && (scan_addr_q != kept_count_q);
	assign drained = (scan_addr_q == kept_count_q) && !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		{k_col, k_row} = rd_data_s1;
		dx_n = (k_col >= c_q) ? k_col - c_q : c_q - k_col;
		dy_n = (k_row >= r_q) ? k_row - r_q : r_q - k_row;
		dist_sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
		lt = CMP_W'(dist_sum) < CMP_W'(min_dist_sq_q);
	end

	always_comb begin
		acc = !blk_q && !hit_q;
		cnt_inc = kept_count_q + CNT_W'(1);
		mc_ext = LIM_W'(max_corners_q);
		lim = (mc_ext == '0 || mc_ext > LIM_W'(MAX_KEPT)) ? LIM_W'(MAX_KEPT) : mc_ext;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			c_q <= col;
			r_q <= row;
			dvc_q <= col;
			dvr_q <= row;
			remc_q <= '0;
			remr_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvc_q <= {dvc_q[COORD_BITS-2:0], gec};
			dvr_q <= {dvr_q[COORD_BITS-2:0], ger};
			remc_q <= remc_n;
			remr_q <= remr_n;
		end
		// A kept corner lies in a neighboring cell when its pixel coordinate falls
		// within [(q - 1) * cell, (q + 2) * cell) for the candidate's cell index q.
		lo_c_q <= (dvc_q == '0) ? '0 : BND_W'(dvc_q - COORD_BITS'(1)) * BND_W'(cs_eff);
		hi_c_q <= (BND_W'(dvc_q) + BND_W'(2)) * BND_W'(cs_eff);
		lo_r_q <= (dvr_q == '0) ? '0 : BND_W'(dvr_q - COORD_BITS'(1)) * BND_W'(cs_eff);
		hi_r_q <= (BND_W'(dvr_q) + BND_W'(2)) * BND_W'(cs_eff);
		if (rd_en) begin
			rd_data_s1 <= kept_mem[scan_addr_q[IDX_W-1:0]];
		end
		dx_s2 <= dx_n;
		dy_s2 <= dy_n;
		near_s2 <= (BND_W'(k_col) >= lo_c_q) && (BND_W'(k_col) < hi_c_q) &&
			(BND_W'(k_row) >= lo_r_q) && (BND_W'(k_row) < hi_r_q);
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		near_s3 <= near_s2;
		if (state_q == ST_FIN && acc) begin
			kept_mem[kept_count_q[IDX_W-1:0]] <= {c_q, r_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			scan_addr_q <= '0;
			kept_count_q <= '0;
			budget_q <= 1'b0;
			blk_q <= 1'b0;
			hit_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			res_valid_q <= 1'b0;
			accepted_q <= 1'b0;
			done_res_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			res_valid_q <= (state_q == ST_FIN);
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && near_s3 && lt) begin
				hit_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						hit_q <= 1'b0;
						scan_addr_q <= '0;
						div_cnt_q <= DC_W'(COORD_BITS);
						if (first) begin
							kept_count_q <= '0;
							budget_q <= 1'b0;
							blk_q <= 1'b0;
							state_q <= ST_DIV;
						end else begin
							blk_q <= budget_q;
							state_q <= budget_q ? ST_FIN : ST_DIV;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - DC_W'(1);
					if (div_cnt_q == DC_W'(1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end
					if (drained) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					accepted_q <= acc;
					out_col_q <= c_q;
					out_row_q <= r_q;
					if (acc) begin
						kept_count_q <= cnt_inc;
						budget_q <= LIM_W'(cnt_inc) >= lim;
						done_res_q <= LIM_W'(cnt_inc) >= lim;
					end else begin
						done_res_q <= budget_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign accepted = accepted_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign done_res = done_res_q;

	`CMDF_ASSERT(a_res_when_idle, clk, arst_n, res_valid |-> !busy, "result strobed while busy")
	`CMDF_ASSERT_NXT(a_res_one_cycle, clk, arst_n, res_valid, !res_valid, "result held past one cycle")
	`CMDF_ASSERT(a_count_bound, clk, arst_n, kept_count_q <= CNT_W'(MAX_KEPT), "kept count overflow")
	`CMDF_ASSERT(a_full_is_done, clk, arst_n, (kept_count_q == CNT_W'(MAX_KEPT)) |-> budget_q, "storage full without budget flag")
	`CMDF_ASSERT(a_accept_fits, clk, arst_n, (state_q == ST_FIN && acc) |-> (kept_count_q < CNT_W'(MAX_KEPT)), "acceptance with full storage")
endmodule
`default_nettype wire
